// ===== rtl/core/x86s_pkg.sv =====
// Shared types, codes and helper functions for the x86 string instruction unit.
`default_nettype none

package x86s_pkg;

  // Input command codes
  localparam logic [1:0] CMD_START   = 2'd0;
  localparam logic [1:0] CMD_RD_DATA = 2'd1;
  localparam logic [1:0] CMD_WR_ACK  = 2'd2;

  // Operation codes
  localparam logic [2:0] OP_MOVS = 3'd0;
  localparam logic [2:0] OP_STOS = 3'd1;
  localparam logic [2:0] OP_CMPS = 3'd2;
  localparam logic [2:0] OP_LODS = 3'd3;
  localparam logic [2:0] OP_SCAS = 3'd4;

  // Access width codes
  localparam logic [1:0] WIDTH_BYTE  = 2'd0;
  localparam logic [1:0] WIDTH_WORD  = 2'd1;
  localparam logic [1:0] WIDTH_DWORD = 2'd2;
  localparam logic [1:0] WIDTH_BAD   = 2'd3;

  // Repeat prefix codes
  localparam logic [1:0] REP_NONE = 2'd0;
  localparam logic [1:0] REP_E    = 2'd1;
  localparam logic [1:0] REP_NE   = 2'd2;
  localparam logic [1:0] REP_BAD  = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_RD   = 2'd0;
  localparam logic [1:0] KIND_WR   = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  // Completion status
  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_BAD_WIDTH = 1'b1;

  // Flag bit positions in cmp_flags
  localparam int unsigned FLAG_ZF = 3;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_RD_SRC = 4'b0010,
    PH_RD_DST = 4'b0100,
    PH_WR_DST = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  op;
    logic [1:0]  width_code;
    logic [1:0]  rep_mode;
    logic        addr32;
    logic        direction;
    logic [15:0] src_segment;
    logic [15:0] dst_segment;
    logic [31:0] src_offset;
    logic [31:0] dst_offset;
    logic [15:0] count;
    logic [31:0] data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [32:0] address;
    logic [1:0]  size_code;
    logic [31:0] write_data;
    logic [31:0] final_src_offset;
    logic [31:0] final_dst_offset;
    logic [15:0] final_count;
    logic [31:0] acc_value;
    logic [5:0]  cmp_flags;
    logic        flags_valid;
    logic        status;
  } out_item_t;

  // Architectural state of the running instruction
  typedef struct packed {
    phase_e      phase;
    logic [2:0]  op;
    logic [1:0]  width;
    logic [1:0]  rep;
    logic        addr32;
    logic        direction;
    logic [15:0] src_base;
    logic [15:0] dst_base;
    logic [31:0] src_index;
    logic [31:0] dst_index;
    logic [15:0] remaining;
    logic [31:0] acc;
    logic [31:0] first_operand;
    logic [5:0]  flags;
    logic        flags_vld;
  } state_t;

  function automatic logic [31:0] wmask(input logic [1:0] w);
    logic [31:0] m;
    case (w)
      WIDTH_BYTE: m = 32'h0000_00FF;
      WIDTH_WORD: m = 32'h0000_FFFF;
      default:    m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  // Advance an index by the element size; 16-bit mode wraps in the low half
  function automatic logic [31:0] step_index(input logic [31:0] idx, input logic [1:0] w,
                                             input logic a32, input logic dir);
    logic [3:0]  n;
    logic [31:0] nv;
    n  = 4'd1 << w;
    nv = dir ? (idx - 32'(n)) : (idx + 32'(n));
    return a32 ? nv : {idx[31:16], nv[15:0]};
  endfunction

  function automatic logic [32:0] lin_addr(input logic [15:0] seg, input logic [31:0] idx,
                                           input logic a32);
    logic [31:0] off;
    off = a32 ? idx : {16'h0000, idx[15:0]};
    return 33'({seg, 4'h0}) + 33'(off);
  endfunction

  // Subtract flags of a - b at the given width: CF PF AF ZF SF OF from bit 0
  function automatic logic [5:0] cmp_flags(input logic [31:0] a_in, input logic [31:0] b_in,
                                           input logic [1:0] w);
    logic [31:0] m;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] r;
    logic [31:0] ov;
    logic [4:0]  top;
    logic [5:0]  f;
    m  = wmask(w);
    a  = a_in & m;
    b  = b_in & m;
    r  = (a - b) & m;
    ov = (a ^ b) & (a ^ r);
    case (w)
      WIDTH_BYTE: top = 5'd7;
      WIDTH_WORD: top = 5'd15;
      default:    top = 5'd31;
    endcase
    f[0] = (a < b);
    f[1] = ~(^r[7:0]);
    f[2] = a[4] ^ b[4] ^ r[4];
    f[3] = (r == 32'h0);
    f[4] = r[top];
    f[5] = ov[top];
    return f;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/x86s_step.sv =====
// Next-state and result logic for one transaction of the string unit.
`default_nettype none

module x86s_step import x86s_pkg::*; (
  input  var state_t    state_i,
  input  var in_item_t  item_i,
  output state_t        state_o,
  output out_item_t     res_o
);

  state_t    st_d;
  out_item_t res;
  logic      emit_done;
  logic      done_bad;
  logic      finish;
  logic      issue_first;
  logic      more;
  phase_e    req_phase;

  always_comb begin
    st_d        = state_i;
    res         = '0;
    emit_done   = 1'b0;
    done_bad    = 1'b0;
    finish      = 1'b0;
    issue_first = 1'b0;
    more        = 1'b0;
    req_phase   = state_i.phase;

    if (item_i.cmd == CMD_START) begin
      st_d.op            = item_i.op;
      st_d.width         = item_i.width_code;
      st_d.rep           = (item_i.rep_mode == REP_BAD) ? REP_NONE : item_i.rep_mode;
      st_d.addr32        = item_i.addr32;
      st_d.direction     = item_i.direction;
      st_d.src_base      = item_i.src_segment;
      st_d.dst_base      = item_i.dst_segment;
      st_d.src_index     = item_i.src_offset;
      st_d.dst_index     = item_i.dst_offset;
      st_d.remaining     = item_i.count;
      st_d.acc           = item_i.data;
      st_d.first_operand = '0;
      st_d.flags         = '0;
      st_d.flags_vld     = 1'b0;
      if (item_i.width_code == WIDTH_BAD) begin
        emit_done = 1'b1;
        done_bad  = 1'b1;
      end else if (item_i.op > OP_SCAS) begin
        emit_done = 1'b1;
      end else if (st_d.rep != REP_NONE && item_i.count == 16'h0) begin
        emit_done = 1'b1;
      end else begin
        issue_first = 1'b1;
      end
    end else begin
      unique case (state_i.phase)
        PH_RD_SRC: begin
          if (item_i.cmd == CMD_RD_DATA) begin
            if (state_i.op == OP_MOVS) begin
              st_d.first_operand = item_i.data & wmask(state_i.width);
              req_phase          = PH_WR_DST;
            end else if (state_i.op == OP_CMPS) begin
              st_d.first_operand = item_i.data & wmask(state_i.width);
              req_phase          = PH_RD_DST;
            end else begin
              // lods: merge only the covered low bits
              st_d.acc = (state_i.acc & ~wmask(state_i.width)) |
                         (item_i.data & wmask(state_i.width));
              finish   = 1'b1;
            end
          end
        end
        PH_RD_DST: begin
          if (item_i.cmd == CMD_RD_DATA) begin
            st_d.flags     = cmp_flags((state_i.op == OP_CMPS) ? state_i.first_operand
                                                                : state_i.acc,
                                       item_i.data, state_i.width);
            st_d.flags_vld = 1'b1;
            finish         = 1'b1;
          end
        end
        PH_WR_DST: begin
          if (item_i.cmd == CMD_WR_ACK) begin
            finish = 1'b1;
          end
        end
        default: begin
          emit_done = 1'b1;
        end
      endcase
    end

    // End of one element: step indices, count down under a repeat prefix, test termination
    if (finish) begin
      if (st_d.op == OP_MOVS || st_d.op == OP_CMPS || st_d.op == OP_LODS) begin
        st_d.src_index = step_index(st_d.src_index, st_d.width, st_d.addr32, st_d.direction);
      end
      if (st_d.op != OP_LODS) begin
        st_d.dst_index = step_index(st_d.dst_index, st_d.width, st_d.addr32, st_d.direction);
      end
      if (st_d.rep != REP_NONE) begin
        st_d.remaining = st_d.remaining - 16'd1;
        more           = (st_d.remaining != 16'h0);
        if (st_d.op == OP_CMPS || st_d.op == OP_SCAS) begin
          if (st_d.rep == REP_E && !st_d.flags[FLAG_ZF]) more = 1'b0;
          if (st_d.rep == REP_NE && st_d.flags[FLAG_ZF]) more = 1'b0;
        end
      end
      if (more) issue_first = 1'b1;
      else      emit_done   = 1'b1;
    end

    if (issue_first) begin
      if (st_d.op == OP_STOS) begin
        st_d.first_operand = st_d.acc & wmask(st_d.width);
        req_phase          = PH_WR_DST;
      end else if (st_d.op == OP_SCAS) begin
        req_phase = PH_RD_DST;
      end else begin
        req_phase = PH_RD_SRC;
      end
    end

    if (emit_done) begin
      st_d.phase           = PH_IDLE;
      res.kind             = KIND_DONE;
      res.final_src_offset = st_d.src_index;
      res.final_dst_offset = st_d.dst_index;
      res.final_count      = st_d.remaining;
      res.acc_value        = st_d.acc;
      res.cmp_flags        = st_d.flags;
      res.flags_valid      = st_d.flags_vld;
      res.status           = done_bad ? STATUS_BAD_WIDTH : STATUS_OK;
    end else begin
      st_d.phase    = req_phase;
      res.size_code = st_d.width;
      if (req_phase == PH_RD_SRC) begin
        res.kind    = KIND_RD;
        res.address = lin_addr(st_d.src_base, st_d.src_index, st_d.addr32);
      end else if (req_phase == PH_RD_DST) begin
        res.kind    = KIND_RD;
        res.address = lin_addr(st_d.dst_base, st_d.dst_index, st_d.addr32);
      end else begin
        res.kind       = KIND_WR;
        res.address    = lin_addr(st_d.dst_base, st_d.dst_index, st_d.addr32);
        res.write_data = st_d.first_operand & wmask(st_d.width);
      end
    end
  end

  assign state_o = st_d;
  assign res_o   = res;

endmodule

`default_nettype wire

// ===== rtl/core/x86_string_instruction_unit_top.sv =====
// Top level of the x86 string instruction unit: input register, step logic, result register.
// A transaction goes from the input register through the step logic into the result register,
// and waits in the input register while the result register is stalled.
// Throughput: one transaction per cycle while the result channel does not stall, set by the
// single step stage that updates the instruction state from the input register.
// Reset (rst_ni low, asynchronous): both registers empty, phase idle, all instruction state zero.
`default_nettype none

module x86_string_instruction_unit_top import x86s_pkg::*; (
  input  var logic      clk_i,
  input  var logic      rst_ni,
  // input channel
  input  var logic      in_valid_i,
  output logic          in_stall_o,
  input  var in_item_t  in_item_i,
  // result channel
  output logic          out_valid_o,
  input  var logic      out_stall_i,
  output out_item_t     out_item_o
);

  // Input register: decouples the input from a stalled result register
  logic      in_vld_q;
  in_item_t  in_q;
  // Result register
  logic      out_vld_q;
  out_item_t out_q;
  // Instruction state
  state_t    state_q;
  state_t    state_d;
  out_item_t res;

  logic      advance;
  logic      in_take;

  // The held transaction moves on whenever the result register is free or draining
  assign advance    = in_vld_q & (~out_vld_q | ~out_stall_i);
  assign in_stall_o = in_vld_q & ~advance;
  assign in_take    = in_valid_i & ~in_stall_o;

  x86s_step u_step (
    .state_i (state_q),
    .item_i  (in_q),
    .state_o (state_d),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  // State commits only when its transaction's result is written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_IDLE, default: '0};
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire
